// ===== rtl/mss_pkg.sv =====
package mss_pkg;

  localparam int LEVELS      = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int POS_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int BUD_W  = $clog2(LEVELS + 1);
  localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] process_id;
    logic [2:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] granted_id;
    logic [2:0] granted_level;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage

// ===== rtl/mss_ctrl.sv =====
module mss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mss_pkg::ctl_t ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!rsp_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign ctl.load  = (state == S_IDLE) && req_valid;
  assign ctl.exec  = (state == S_EXEC);

endmodule

// ===== rtl/mss_datapath.sv =====
module mss_datapath (
  input  logic          clk,
  input  logic          rst,
  input  mss_pkg::ctl_t ctl,
  input  mss_pkg::req_t req,
  output mss_pkg::rsp_t rsp
);

  mss_pkg::req_t item;

  logic [mss_pkg::CNT_W-1:0]   count  [mss_pkg::LEVELS];
  logic [mss_pkg::POS_W-1:0]   head   [mss_pkg::LEVELS];
  logic [mss_pkg::BUD_W-1:0]   budget [mss_pkg::LEVELS];

  logic [mss_pkg::ID_BITS-1:0] mem [mss_pkg::MEM_DEPTH];
  logic [mss_pkg::ID_BITS-1:0] rdata;

  logic [1:0]                  status;
  logic [mss_pkg::LVL_W-1:0]   grant_level;
  logic                        grant;

  logic [mss_pkg::LVL_W-1:0]   enq_level;
  logic [mss_pkg::POS_W-1:0]   tail;
  logic [mss_pkg::SUM_W-1:0]   tail_sum;
  logic                        enq_full;

  logic                        hit_budget;
  logic [mss_pkg::LVL_W-1:0]   sel_budget;
  logic                        hit_any;
  logic [mss_pkg::LVL_W-1:0]   sel_any;
  logic [mss_pkg::LVL_W-1:0]   sel;
  logic                        reload;

  logic                        mem_we;
  logic                        mem_re;
  logic [mss_pkg::ADDR_W-1:0]  waddr;
  logic [mss_pkg::ADDR_W-1:0]  raddr;

  always_comb begin
    if (32'(item.priority_req) >= mss_pkg::LEVELS) begin
      enq_level = mss_pkg::LVL_W'(mss_pkg::LEVELS - 1);
    end else begin
      enq_level = mss_pkg::LVL_W'(item.priority_req);
    end
  end

  always_comb begin
    enq_full = (count[enq_level] == mss_pkg::CNT_W'(mss_pkg::QUEUE_DEPTH));
    tail_sum = mss_pkg::SUM_W'(head[enq_level]) + mss_pkg::SUM_W'(count[enq_level]);
    if (tail_sum >= mss_pkg::SUM_W'(mss_pkg::QUEUE_DEPTH)) begin
      tail = mss_pkg::POS_W'(tail_sum - mss_pkg::SUM_W'(mss_pkg::QUEUE_DEPTH));
    end else begin
      tail = mss_pkg::POS_W'(tail_sum);
    end
  end

  always_comb begin
    hit_budget = 1'b0;
    sel_budget = '0;
    hit_any    = 1'b0;
    sel_any    = '0;
    for (int i = mss_pkg::LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        hit_any = 1'b1;
        sel_any = mss_pkg::LVL_W'(i);
        if (budget[i] != '0) begin
          hit_budget = 1'b1;
          sel_budget = mss_pkg::LVL_W'(i);
        end
      end
    end
    reload = !hit_budget;
    sel    = hit_budget ? sel_budget : sel_any;
  end

  assign mem_we = ctl.exec && (item.command == mss_pkg::CMD_ENQUEUE) && !enq_full;
  assign mem_re = ctl.exec && (item.command == mss_pkg::CMD_DEQUEUE) && hit_any;
  assign waddr  = mss_pkg::ADDR_W'(32'(enq_level) * mss_pkg::QUEUE_DEPTH)
                + mss_pkg::ADDR_W'(tail);
  assign raddr  = mss_pkg::ADDR_W'(32'(sel) * mss_pkg::QUEUE_DEPTH)
                + mss_pkg::ADDR_W'(head[sel]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= mss_pkg::ID_BITS'(item.process_id);
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item <= req;
    end
    if (ctl.exec) begin
      status      <= mss_pkg::STATUS_DONE;
      grant       <= 1'b0;
      grant_level <= '0;
      if (item.command == mss_pkg::CMD_ENQUEUE) begin
        if (enq_full) begin
          status <= mss_pkg::STATUS_FULL;
        end
      end else if (!hit_any) begin
        status <= mss_pkg::STATUS_NONE;
      end else begin
        grant       <= 1'b1;
        grant_level <= sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mss_pkg::LEVELS; i++) begin
        count[i]  <= '0;
        head[i]   <= '0;
        budget[i] <= mss_pkg::BUD_W'(mss_pkg::LEVELS - i);
      end
    end else if (ctl.exec) begin
      if (item.command == mss_pkg::CMD_ENQUEUE) begin
        if (!enq_full) begin
          count[enq_level] <= count[enq_level] + mss_pkg::CNT_W'(1);
        end
      end else begin
        if (reload) begin
          for (int i = 0; i < mss_pkg::LEVELS; i++) begin
            budget[i] <= mss_pkg::BUD_W'(mss_pkg::LEVELS - i);
          end
        end
        if (hit_any) begin
          count[sel] <= count[sel] - mss_pkg::CNT_W'(1);
          if (head[sel] == mss_pkg::POS_W'(mss_pkg::QUEUE_DEPTH - 1)) begin
            head[sel] <= '0;
          end else begin
            head[sel] <= head[sel] + mss_pkg::POS_W'(1);
          end
          if (reload) begin
            budget[sel] <= mss_pkg::BUD_W'(mss_pkg::LEVELS - 1 - 32'(sel));
          end else begin
            budget[sel] <= budget[sel] - mss_pkg::BUD_W'(1);
          end
        end
      end
    end
  end

  assign rsp.status        = status;
  assign rsp.granted_id    = grant ? 8'(rdata) : 8'd0;
  assign rsp.granted_level = 3'(grant_level);

endmodule

// ===== rtl/multilevel_slot_scheduler.sv =====
// Multilevel queue scheduler with per-level slot budgets. Each transaction
// on the request channel is an enqueue or a dequeue and yields exactly one
// response. Transactions are handled one at a time: a request is taken in
// the idle state, the level scan and the single queue memory access run in
// the next cycle, and the response is presented from the cycle after that
// and held while the response is stalled; the granted id comes from the
// queue memory's registered read. The queue memory
// needs no clearing after reset; requests are taken from the first cycle.
module multilevel_slot_scheduler (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mss_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mss_pkg::rsp_t rsp
);

  mss_pkg::ctl_t ctl;

  mss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctl       (ctl)
  );

  mss_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .req (req),
    .rsp (rsp)
  );

endmodule

// ===== tb/tb_multilevel_slot_scheduler.sv =====
`timescale 1ns / 100ps

module tb_multilevel_slot_scheduler;

  localparam int RANDOM_REQUESTS = 1450;

  class grant_scoreboard;
    logic [mss_pkg::ID_BITS-1:0] level_ids [mss_pkg::LEVELS][mss_pkg::QUEUE_DEPTH];
    int                          level_head [mss_pkg::LEVELS];
    int                          level_count [mss_pkg::LEVELS];
    int                          level_budget [mss_pkg::LEVELS];
    mss_pkg::rsp_t               grants_due [$];
    int                          errors;

    function new();
      errors = 0;
      foreach (level_head[lv]) begin
        level_head[lv] = 0;
        level_count[lv] = 0;
      end
      reload_budgets();
    endfunction

    function void reload_budgets();
      foreach (level_budget[lv]) begin
        level_budget[lv] = mss_pkg::LEVELS - lv;
      end
    endfunction

    function int first_ready_level();
      for (int lv = 0; lv < mss_pkg::LEVELS; lv++) begin
        if (level_count[lv] != 0 && level_budget[lv] != 0) begin
          return lv;
        end
      end
      return mss_pkg::LEVELS;
    endfunction

    function void note_request(mss_pkg::req_t r);
      mss_pkg::rsp_t due;
      int            lv;
      due = '0;
      if (r.command == mss_pkg::CMD_ENQUEUE) begin
        lv = r.priority_req;
        if (lv >= mss_pkg::LEVELS) begin
          lv = mss_pkg::LEVELS - 1;
        end
        if (level_count[lv] >= mss_pkg::QUEUE_DEPTH) begin
          due.status = mss_pkg::STATUS_FULL;
        end else begin
          level_ids[lv][(level_head[lv] + level_count[lv]) % mss_pkg::QUEUE_DEPTH] =
            r.process_id[mss_pkg::ID_BITS-1:0];
          level_count[lv]++;
          due.status = mss_pkg::STATUS_DONE;
        end
      end else begin
        lv = first_ready_level();
        if (lv >= mss_pkg::LEVELS) begin
          reload_budgets();
          lv = first_ready_level();
        end
        if (lv >= mss_pkg::LEVELS) begin
          due.status = mss_pkg::STATUS_NONE;
        end else begin
          due.status = mss_pkg::STATUS_DONE;
          due.granted_id = 8'(level_ids[lv][level_head[lv]]);
          due.granted_level = 3'(lv);
          level_head[lv] = (level_head[lv] + 1) % mss_pkg::QUEUE_DEPTH;
          level_count[lv]--;
          level_budget[lv]--;
        end
      end
      grants_due.push_back(due);
    endfunction

    function void check_grant(mss_pkg::rsp_t got);
      mss_pkg::rsp_t due;
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected response status=%0d id=%0d level=%0d",
                 $time, got.status, got.granted_id, got.granted_level);
        errors++;
        return;
      end
      due = grants_due.pop_front();
      if (got.status !== due.status) begin
        $display("%0t: status expected %0d actual %0d", $time, due.status, got.status);
        errors++;
      end
      if (got.granted_id !== due.granted_id) begin
        $display("%0t: granted_id expected %0d actual %0d",
                 $time, due.granted_id, got.granted_id);
        errors++;
      end
      if (got.granted_level !== due.granted_level) begin
        $display("%0t: granted_level expected %0d actual %0d",
                 $time, due.granted_level, got.granted_level);
        errors++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  mss_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_stall;
  mss_pkg::rsp_t rsp;

  grant_scoreboard board;
  bit              calm;

  multilevel_slot_scheduler uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAIL multilevel_slot_scheduler");
    $finish;
  end

  function automatic mss_pkg::req_t make_req(logic cmd, logic [7:0] pid, logic [2:0] lv);
    mss_pkg::req_t r;
    r.command = cmd;
    r.process_id = pid;
    r.priority_req = lv;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll = $urandom_range(0, 99);
    if (calm || roll < 60) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(input mss_pkg::req_t r);
    int gap;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(r);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      board.check_grant(rsp);
    end
  end

  // response back-pressure: stretches of none, light and bursty stalls
  initial begin
    int mode;
    int span;
    int hold;
    rsp_stall = 1'b0;
    hold = 0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        if (hold > 0) begin
          hold--;
          rsp_stall <= 1'b1;
        end else if (mode == 1) begin
          rsp_stall <= ($urandom_range(0, 3) == 0);
        end else if (mode == 2 && $urandom_range(0, 9) == 0) begin
          hold = $urandom_range(5, 30);
          rsp_stall <= 1'b1;
        end else begin
          rsp_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    mss_pkg::req_t r;
    int            phase_left;
    int            enq_pct;
    logic [2:0]    focus;
    req_valid = 1'b0;
    req = '0;
    rst = 1'b1;
    calm = 1'b0;
    board = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty scheduler, one id per level with extreme ids, then overflow the last level
    send_request(make_req(mss_pkg::CMD_DEQUEUE, 8'hFF, 3'd7));
    send_request(make_req(mss_pkg::CMD_ENQUEUE, 8'h00, 3'd0));
    send_request(make_req(mss_pkg::CMD_ENQUEUE, 8'hFF, 3'(mss_pkg::LEVELS - 1)));
    for (int lv = 1; lv < mss_pkg::LEVELS - 1; lv++) begin
      send_request(make_req(mss_pkg::CMD_ENQUEUE, 8'($urandom_range(1, 254)), 3'(lv)));
    end
    for (int k = 0; k < mss_pkg::QUEUE_DEPTH; k++) begin
      send_request(make_req(mss_pkg::CMD_ENQUEUE, 8'($urandom_range(0, 255)),
                            3'(mss_pkg::LEVELS - 1)));
    end

    phase_left = 0;
    enq_pct = 50;
    focus = '0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 120);
        enq_pct = 20 + 30 * $urandom_range(0, 2);
        focus = 3'($urandom_range(0, mss_pkg::LEVELS - 1));
        calm = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      r.command = ($urandom_range(0, 99) < enq_pct) ? mss_pkg::CMD_ENQUEUE
                                                     : mss_pkg::CMD_DEQUEUE;
      r.process_id = 8'($urandom_range(0, 255));
      r.priority_req = ($urandom_range(0, 2) == 0) ? focus
                                                   : 3'($urandom_range(0, 7));
      send_request(r);
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    while (board.grants_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS multilevel_slot_scheduler");
    end else begin
      $display("FAIL multilevel_slot_scheduler");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mss_pkg.sv
rtl/mss_ctrl.sv
rtl/mss_datapath.sv
rtl/multilevel_slot_scheduler.sv
tb/tb_multilevel_slot_scheduler.sv
